[sv/chisq_pkg.sv]
package chisq_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int CHI_W       = 28;
	localparam int NUM_BINS    = 10;
	localparam int MIN_SAMPLES = 10;
	localparam int MAX_SAMPLES = 65536;

	// counters must hold MAX_SAMPLES itself
	localparam int TOT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int BIN_W  = $clog2(NUM_BINS);
	// dividend of one statistic term: d^2 scaled by 256
	localparam int DQ_W   = 2 * TOT_W + 8;
	localparam int STEP_W = $clog2(DQ_W + 1);

	// floor(x / 10) = (x * 52429) >> 19 for x below 2^17
	localparam int             RECIP_W  = 16;
	localparam int             RECIP_SH = 19;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(52429);

	localparam logic [SAMPLE_W-1:0] MAX_VALUE_RESET = SAMPLE_W'(10000);
	localparam logic [SAMPLE_W-1:0] WIDTH_RESET     = SAMPLE_W'(10000 / NUM_BINS);
	localparam logic [CHI_W-1:0]    CHI_MAX         = {CHI_W{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_BDIV,
		S_UPDATE,
		S_CHECK,
		S_SQUARE,
		S_TDIV,
		S_ACCUM,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_FEW = 2'd1,
		STAT_OVF = 2'd2
	} status_t;

endpackage

[sv/chi_square_uniformity.sv]
// channel | signals                        | contents
// s       | s_tvalid s_tready s_tdata s_tlast | sample in, s_tlast marks batch end
// m       | m_tvalid m_tready m_tdata m_tuser | statistic (q8) and status
// cfg     | cfg_we cfg_data                | max_value, bin width derived on write
//
// a sample is accepted, then divided by the bin width in the shared restoring
// divider (16 quotient bits), then the bin counters are updated
// the last sample adds a check state, per bin a squaring state, the d^2*256/E
// divider (42 quotient bits) and an accumulate state, then the result load
// reset clears all counters; max_value comes up as 10000
// a finished result waits in the output register; a new batch can run meanwhile
// and only the next result load waits on m_tready
module chi_square_uniformity
	import chisq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [15:0] sample
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,   // [27:0] chi_square_q8, [31:28] zero
	output logic [1:0]          m_tuser,   // [1:0] status
	input  logic                cfg_we,
	input  logic [SAMPLE_W-1:0] cfg_data
);

	state_t                  state_q, state_nx;
	logic [SAMPLE_W-1:0]     width_q;
	logic [TOT_W-1:0]        bin_cnt_q [NUM_BINS];
	logic [TOT_W-1:0]        total_q;
	logic                    ovf_q;
	logic                    last_q;
	logic [BIN_W-1:0]        k_q;
	logic [CHI_W-1:0]        acc_q;
	status_t                 status_q;
	logic [TOT_W-1:0]        expect_q;
	logic [STEP_W-1:0]       step_q;
	logic [TOT_W-1:0]        rem_q;
	logic [DQ_W-1:0]         dq_q;
	logic                    m_valid_q;
	logic [CHI_W-1:0]        chi_q;
	status_t                 stat_out_q;

	// control decoded from state
	logic                    div_step;
	logic                    final_step;
	logic                    out_free;
	logic                    emit_go;

	// datapath
	logic [SAMPLE_W+RECIP_W-1:0] wprod;
	logic [SAMPLE_W-1:0]         wnew;
	logic [TOT_W+RECIP_W-1:0]    eprod;
	logic [TOT_W-1:0]            enew;
	logic [TOT_W-1:0]            divisor;
	logic [TOT_W:0]              shifted;
	logic                        ge;
	logic [TOT_W-1:0]            rem_nx;
	logic [SAMPLE_W-1:0]         quo;
	logic [BIN_W-1:0]            bin;
	logic [BIN_W-1:0]            rd_idx;
	logic [TOT_W-1:0]            cnt;
	logic [TOT_W-1:0]            diff;
	logic [2*TOT_W-1:0]          sq;
	logic [DQ_W:0]               sum;
	logic [CHI_W-1:0]            acc_nx;

	assign wprod = SAMPLE_W'(0) + cfg_data * RECIP;
	assign wnew  = (SAMPLE_W'(wprod >> RECIP_SH) == '0) ? SAMPLE_W'(1)
		: SAMPLE_W'(wprod >> RECIP_SH);
	assign eprod = total_q * RECIP;
	assign enew  = TOT_W'(eprod >> RECIP_SH);

	// shared restoring divider, one quotient bit per cycle
	assign divisor = (state_q == S_BDIV) ? TOT_W'(width_q) : expect_q;
	assign shifted = {rem_q, dq_q[DQ_W-1]};
	assign ge      = shifted >= {1'b0, divisor};
	assign rem_nx  = ge ? TOT_W'(shifted - {1'b0, divisor}) : TOT_W'(shifted);

	assign quo    = dq_q[SAMPLE_W-1:0];
	assign bin    = (quo > SAMPLE_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : quo[BIN_W-1:0];
	assign rd_idx = (state_q == S_UPDATE) ? bin : k_q;
	assign cnt    = bin_cnt_q[rd_idx];
	assign diff   = (cnt >= expect_q) ? cnt - expect_q : expect_q - cnt;
	assign sq     = diff * diff;

	assign sum    = (DQ_W+1)'(acc_q) + (DQ_W+1)'(dq_q);
	assign acc_nx = (sum > (DQ_W+1)'(CHI_MAX)) ? CHI_MAX : sum[CHI_W-1:0];

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nx = S_BDIV;
			end
			S_BDIV: begin
				if (final_step) state_nx = S_UPDATE;
			end
			S_UPDATE: begin
				state_nx = last_q ? S_CHECK : S_IDLE;
			end
			S_CHECK: begin
				if (ovf_q || total_q < TOT_W'(MIN_SAMPLES)) state_nx = S_EMIT;
				else state_nx = S_SQUARE;
			end
			S_SQUARE: state_nx = S_TDIV;
			S_TDIV: begin
				if (final_step) state_nx = S_ACCUM;
			end
			S_ACCUM: begin
				state_nx = (k_q == BIN_W'(NUM_BINS - 1)) ? S_EMIT : S_SQUARE;
			end
			S_EMIT: begin
				if (out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready   = 1'b0;
		div_step   = 1'b0;
		final_step = 1'b0;
		emit_go    = 1'b0;
		out_free   = !m_valid_q || m_tready;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_BDIV: begin
				div_step   = 1'b1;
				final_step = step_q == STEP_W'(SAMPLE_W - 1);
			end
			S_TDIV: begin
				div_step   = 1'b1;
				final_step = step_q == STEP_W'(DQ_W - 1);
			end
			S_EMIT: emit_go = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			width_q    <= WIDTH_RESET;
			total_q    <= '0;
			ovf_q      <= 1'b0;
			m_valid_q  <= 1'b0;
			step_q     <= '0;
			k_q        <= '0;
			last_q     <= 1'b0;
			status_q   <= STAT_OK;
			for (int i = 0; i < NUM_BINS; i++) bin_cnt_q[i] <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) width_q <= wnew;

			if (s_tvalid && s_tready) last_q <= s_tlast;

			if (div_step) step_q <= final_step ? '0 : step_q + STEP_W'(1);

			if (state_q == S_UPDATE) begin
				if (total_q >= TOT_W'(MAX_SAMPLES)) begin
					ovf_q <= 1'b1;
				end else begin
					total_q <= total_q + TOT_W'(1);
					for (int i = 0; i < NUM_BINS; i++)
						if (BIN_W'(i) == bin) bin_cnt_q[i] <= bin_cnt_q[i] + TOT_W'(1);
				end
			end

			if (state_q == S_CHECK) begin
				k_q <= '0;
				if (ovf_q) status_q <= STAT_OVF;
				else if (total_q < TOT_W'(MIN_SAMPLES)) status_q <= STAT_FEW;
				else status_q <= STAT_OK;
			end

			if (state_q == S_ACCUM) k_q <= k_q + BIN_W'(1);

			if (emit_go) begin
				m_valid_q <= 1'b1;
				total_q   <= '0;
				ovf_q     <= 1'b0;
				for (int i = 0; i < NUM_BINS; i++) bin_cnt_q[i] <= '0;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rem_q <= '0;
			dq_q  <= {s_tdata, (DQ_W-SAMPLE_W)'(0)};
		end else if (state_q == S_SQUARE) begin
			rem_q <= '0;
			dq_q  <= {sq, 8'd0};
		end else if (div_step) begin
			rem_q <= rem_nx;
			dq_q  <= {dq_q[DQ_W-2:0], ge};
		end

		if (state_q == S_CHECK) begin
			acc_q    <= '0;
			expect_q <= enew;
		end else if (state_q == S_ACCUM) begin
			acc_q <= acc_nx;
		end

		if (emit_go) begin
			chi_q      <= acc_q;
			stat_out_q <= status_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(32-CHI_W)'(0), chi_q};
	assign m_tuser  = stat_out_q;

`ifndef SYNTHESIS
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_BDIV)
		else $error("accepted sample did not start the bin divide");

	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(MAX_SAMPLES))
		else $error("sample total beyond its limit");

	a_expect_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQUARE || state_q == S_TDIV || state_q == S_ACCUM) |-> expect_q != '0)
		else $error("term divide with zero expected count");

	a_err_no_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
		else $error("error status with nonzero statistic");

	a_bin_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BDIV |-> step_q < STEP_W'(SAMPLE_W))
		else $error("bin divide ran past its step count");
`endif

endmodule
